// ===== sv/bm3_pkg.sv =====
`timescale 1ns / 1ps

package bm3_pkg;

  localparam int PIX_W          = 8;
  localparam int CFG_DATA_W     = 11;
  localparam int CFG_IDX_W      = 2;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int SIZE_RESET     = 1024;
  localparam int WINDOW         = 3;
  localparam int CENTER         = WINDOW / 2;

  localparam logic [PIX_W-1:0] PIX_ON  = 8'd255;
  localparam logic [PIX_W-1:0] PIX_OFF = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OP_MODE      = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_ERODE  = 2'd0,
    OP_DILATE = 2'd1,
    OP_EDGE   = 2'd2
  } op_mode_e;

  // One column of the window, row 0 on top.
  typedef logic [WINDOW-1:0][PIX_W-1:0] col_t;
  // The window, column 0 on the left.
  typedef col_t [WINDOW-1:0] win_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             run_last;
    logic             frame_last;
  } result_t;

  function automatic logic [PIX_W-1:0] judge(win_t win, logic [1:0] mode);
    logic             all_b0;
    logic             any_all;
    logic             any_nb;
    logic [PIX_W-1:0] ctr;
    logic [PIX_W-1:0] v;
    logic [PIX_W-1:0] res;
    all_b0  = 1'b1;
    any_all = 1'b0;
    any_nb  = 1'b0;
    ctr     = win[CENTER][CENTER];
    for (int j = 0; j < WINDOW; j++) begin
      for (int k = 0; k < WINDOW; k++) begin
        v = win[j][k];
        if (!v[0]) begin
          all_b0 = 1'b0;
        end
        if (v != PIX_OFF) begin
          any_all = 1'b1;
          if (!(j == CENTER && k == CENTER)) begin
            any_nb = 1'b1;
          end
        end
      end
    end
    case (mode)
      OP_ERODE:  res = (ctr == PIX_ON && all_b0) ? PIX_ON : PIX_OFF;
      OP_DILATE: res = any_all ? PIX_ON : PIX_OFF;
      OP_EDGE:   res = (ctr == PIX_OFF && any_nb) ? PIX_ON : PIX_OFF;
      default:   res = PIX_OFF;
    endcase
    return res;
  endfunction

endpackage

// ===== sv/bm3_in_if.sv =====
`timescale 1ns / 1ps

interface bm3_in_if import bm3_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  logic             flush;

  modport source (output valid, output pixel_in, output flush, input ready);
  modport sink (input valid, input pixel_in, input flush, output ready);
  modport monitor (input valid, input pixel_in, input flush, input ready);
endinterface

// ===== sv/bm3_out_if.sv =====
`timescale 1ns / 1ps

interface bm3_out_if import bm3_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             run_last;
  logic             frame_last;

  modport source (output valid, output pixel_out, output run_last, output frame_last,
                  input ready);
  modport sink (input valid, input pixel_out, input run_last, input frame_last,
                output ready);
  modport monitor (input valid, input pixel_out, input run_last, input frame_last,
                   input ready);
endinterface

// ===== sv/binary_morphology_3x3_core.sv =====
`timescale 1ns / 1ps

// Streaming 3x3 binary erosion, dilation or outer edge detection on raster-order byte
// pixels, with pixels outside the image counted as 0. Results are 0 or 255 and lag the
// input by one row and one column; after image_height rows, one row of image_width flush
// requests pushes out the bottom row, and flush requests inside the real rows are dropped.
// The block takes one request per clock unless its output stalls. A request waits in the
// input register; its first result enters the output register as the request leaves. A
// request in the last column of a row wider than one pixel, from the second row on, makes
// two results; the second waits in a spare entry behind the output register and leaves
// while the following first-column request, which makes no result, passes through. With
// the output always ready the input therefore never stalls; a stalled output holds the input
// once a request that makes results waits in the input register. The two previous rows
// live in one memory of MAX_WIDTH entries, read when a request is accepted and, outside the
// flush row, written back as it leaves. Writing image_width or image_height restarts the
// frame. The user must write configuration only while the block is idle; no logic checks it.
module binary_morphology_3x3_core import bm3_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  bm3_in_if.sink                in_i,
  bm3_out_if.source             out_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam logic [CW-1:0] LAST_COL_RST =
      CW'(((SIZE_RESET < MAX_WIDTH) ? SIZE_RESET : MAX_WIDTH) - 1);
  localparam logic [RW-1:0] HEIGHT_RST =
      RW'((SIZE_RESET < MAX_HEIGHT) ? SIZE_RESET : MAX_HEIGHT);

  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] lower;
  } line_t;

  typedef struct packed {
    logic r1;
    logic r2;
    logic first;
    logic last;
    logic pad;
  } s1_ctrl_t;

  logic [1:0]    mode_q;
  logic [CW-1:0] last_col_q, last_col_d;
  logic [RW-1:0] height_q, height_d;
  logic          restart;

  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic          padding, in_acc, take;

  logic             s1_v_q;
  s1_ctrl_t         s1_ctrl_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [CW-1:0]    s1_col_q;
  logic             emit1, emit2, out_room, s1_fire;

  line_t            mem [MAX_WIDTH];
  line_t            rd_q, fwd_data_q, rd_line, wr_data;
  logic             fwd_q, wr_en;
  logic [PIX_W-1:0] top, mid;

  win_t             win_q, win_d, win2, base;
  logic [PIX_W-1:0] res1, res2;

  logic    out_v_q, out_v_d, sec_v_q, sec_v_d, out_fire;
  result_t out_q, out_d, sec_q, sec_d;

  always_comb begin
    if (cfg_data_i == '0) begin
      last_col_d = '0;
      height_d   = RW'(1);
    end else begin
      if (32'(cfg_data_i) > MAX_WIDTH) begin
        last_col_d = CW'(MAX_WIDTH - 1);
      end else begin
        last_col_d = CW'(cfg_data_i - 1'b1);
      end
      if (32'(cfg_data_i) > MAX_HEIGHT) begin
        height_d = RW'(MAX_HEIGHT);
      end else begin
        height_d = RW'(cfg_data_i);
      end
    end
  end

  assign restart = cfg_we_i && (cfg_idx_i == CFG_IMAGE_WIDTH || cfg_idx_i == CFG_IMAGE_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= OP_ERODE;
      last_col_q <= LAST_COL_RST;
      height_q   <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OP_MODE:      mode_q     <= cfg_data_i[1:0];
        CFG_IMAGE_WIDTH:  last_col_q <= last_col_d;
        CFG_IMAGE_HEIGHT: height_q   <= height_d;
        default: ;
      endcase
    end
  end

  assign padding     = (row_q == height_q);
  assign in_acc      = in_i.valid && in_i.ready;
  assign take        = in_acc && (padding || !in_i.flush);
  assign in_i.ready  = !s1_v_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (restart) begin
      col_q <= '0;
      row_q <= '0;
    end else if (take) begin
      if (col_q == last_col_q) begin
        col_q <= '0;
        row_q <= padding ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (take) begin
      s1_v_q <= 1'b1;
    end else if (s1_fire) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_pix_q        <= padding ? PIX_OFF : in_i.pixel_in;
      s1_col_q        <= col_q;
      s1_ctrl_q.r1    <= (row_q != '0);
      s1_ctrl_q.r2    <= (row_q > RW'(1));
      s1_ctrl_q.first <= (col_q == '0);
      s1_ctrl_q.last  <= (col_q == last_col_q);
      s1_ctrl_q.pad   <= padding;
    end
  end

  assign emit1    = s1_ctrl_q.r1 && !s1_ctrl_q.first;
  assign emit2    = s1_ctrl_q.r1 && s1_ctrl_q.last;
  assign out_room = (!out_v_q || out_o.ready) && !sec_v_q;
  assign s1_fire  = s1_v_q && (!(emit1 || emit2) || out_room);

  assign wr_en         = s1_fire && !s1_ctrl_q.pad;
  assign wr_data.upper = rd_line.lower;
  assign wr_data.lower = s1_pix_q;

  // A request that reads the entry being written in the same cycle takes the new data.
  always_ff @(posedge clk_i) begin
    if (take) begin
      rd_q       <= mem[col_q];
      fwd_q      <= wr_en && (s1_col_q == col_q);
      fwd_data_q <= wr_data;
    end
    if (wr_en) begin
      mem[s1_col_q] <= wr_data;
    end
  end

  assign rd_line = fwd_q ? fwd_data_q : rd_q;
  assign top     = s1_ctrl_q.r2 ? rd_line.upper : PIX_OFF;
  assign mid     = s1_ctrl_q.r1 ? rd_line.lower : PIX_OFF;

  always_comb begin
    base        = s1_ctrl_q.first ? '0 : win_q;
    win_d[0]    = base[1];
    win_d[1]    = base[2];
    win_d[2][0] = top;
    win_d[2][1] = mid;
    win_d[2][2] = s1_pix_q;
    win2[0]     = win_d[1];
    win2[1]     = win_d[2];
    win2[2]     = '0;
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      win_q <= win_d;
    end
  end

  assign res1     = judge(win_d, mode_q);
  assign res2     = judge(win2, mode_q);
  assign out_fire = out_v_q && out_o.ready;

  always_comb begin
    out_v_d = out_v_q && !out_fire;
    sec_v_d = sec_v_q && !out_fire;
    out_d   = out_q;
    sec_d   = sec_q;
    if (s1_fire && (emit1 || emit2)) begin
      out_v_d = 1'b1;
      if (emit1) begin
        out_d.pixel_out  = res1;
        out_d.run_last   = !emit2;
        out_d.frame_last = 1'b0;
      end else begin
        out_d.pixel_out  = res2;
        out_d.run_last   = 1'b1;
        out_d.frame_last = s1_ctrl_q.pad;
      end
      sec_v_d          = emit1 && emit2;
      sec_d.pixel_out  = res2;
      sec_d.run_last   = 1'b1;
      sec_d.frame_last = s1_ctrl_q.pad;
    end else if (out_fire && sec_v_q) begin
      out_v_d = 1'b1;
      out_d   = sec_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sec_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      sec_v_q <= sec_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sec_q <= sec_d;
  end

  assign out_o.valid      = out_v_q;
  assign out_o.pixel_out  = out_q.pixel_out;
  assign out_o.run_last   = out_q.run_last;
  assign out_o.frame_last = out_q.frame_last;

endmodule

// ===== sv/bm3_checker.sv =====
`timescale 1ns / 1ps

module bm3_checker import bm3_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [PIX_W-1:0] out_pixel_i,
  input logic             out_run_last_i,
  input logic             out_frame_last_i
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pixel_i)
      && $stable(out_run_last_i) && $stable(out_frame_last_i))
    else $error("result changed while stalled");

  a_binary: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_i |-> out_pixel_i == PIX_ON || out_pixel_i == PIX_OFF)
    else $error("result pixel is neither 0 nor 255");

  // The bottom-right result is always the last one of its request.
  a_frame_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_i && out_frame_last_i |-> out_run_last_i)
    else $error("frame_last without run_last");

  // The second result of a request follows its first one at once.
  a_second_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_i && out_ready_i && !out_run_last_i |=> out_valid_i)
    else $error("second result of a request missing");

endmodule

bind binary_morphology_3x3_core bm3_checker u_bm3_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_pixel_i      (out_o.pixel_out),
  .out_run_last_i   (out_o.run_last),
  .out_frame_last_i (out_o.frame_last)
);

// ===== tb/tb_binary_morphology_3x3_core.sv =====
`timescale 1ns / 1ps

module tb_binary_morphology_3x3_core;
  import bm3_pkg::*;

  localparam int MAX_W = DEF_MAX_WIDTH;
  localparam int MAX_H = DEF_MAX_HEIGHT;
  localparam int RANDOM_ITEMS = 1600;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS = 10;
  localparam int TIMEOUT_NS = 100_000_000;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  typedef enum logic {ROW_PIX, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    cfg_idx_e              idx;
    logic [CFG_DATA_W-1:0] val;
    logic [PIX_W-1:0]      pix;
    logic                  fl;
    logic                  fixed;
    logic [PIX_W-1:0]      fixed_px;
  } plan_row_t;

  localparam plan_row_t PLAN [36] = '{
    '{ROW_CFG, CFG_OP_MODE,      CFG_DATA_W'(OP_UNKNOWN), 8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_CFG, CFG_IMAGE_WIDTH,  11'd0,                   8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_CFG, CFG_IMAGE_HEIGHT, 11'd0,                   8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_PIX, CFG_OP_MODE,      11'd0,                   8'd255, 1'b0, 1'b0, 8'd0},
    '{ROW_PIX, CFG_OP_MODE,      11'd0,                   8'd0,   1'b1, 1'b1, PIX_OFF},
    '{ROW_CFG, CFG_OP_MODE,      CFG_DATA_W'(OP_ERODE),   8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_CFG, CFG_IMAGE_WIDTH,  11'd3,                   8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_CFG, CFG_IMAGE_HEIGHT, 11'd3,                   8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_PIX, CFG_OP_MODE,      11'd0,                   8'd255, 1'b0, 1'b0, 8'd0},
    '{ROW_PIX, CFG_OP_MODE,      11'd0,                   8'd255, 1'b0, 1'b0, 8'd0},
    '{ROW_PIX, CFG_OP_MODE,      11'd0,                   8'd255, 1'b0, 1'b0, 8'd0},
    '{ROW_PIX, CFG_OP_MODE,      11'd0,                   8'd0,   1'b1, 1'b0, 8'd0},
    '{ROW_PIX, CFG_OP_MODE,      11'd0,                   8'd255, 1'b0, 1'b0, 8'd0},
    '{ROW_PIX, CFG_OP_MODE,      11'd0,                   8'd255, 1'b0, 1'b0, 8'd0},
    '{ROW_PIX, CFG_OP_MODE,      11'd0,                   8'd255, 1'b0, 1'b0, 8'd0},
    '{ROW_PIX, CFG_OP_MODE,      11'd0,                   8'd255, 1'b0, 1'b0, 8'd0},
    '{ROW_PIX, CFG_OP_MODE,      11'd0,                   8'd255, 1'b0, 1'b0, 8'd0},
    '{ROW_PIX, CFG_OP_MODE,      11'd0,                   8'd255, 1'b0, 1'b0, 8'd0},
    '{ROW_PIX, CFG_OP_MODE,      11'd0,                   8'd0,   1'b1, 1'b0, 8'd0},
    '{ROW_PIX, CFG_OP_MODE,      11'd0,                   8'd255, 1'b0, 1'b0, 8'd0},
    '{ROW_PIX, CFG_OP_MODE,      11'd0,                   8'd0,   1'b1, 1'b0, 8'd0},
    '{ROW_CFG, CFG_OP_MODE,      CFG_DATA_W'(OP_DILATE),  8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_CFG, CFG_IMAGE_WIDTH,  11'd2,                   8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_CFG, CFG_IMAGE_HEIGHT, 11'd1,                   8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_PIX, CFG_OP_MODE,      11'd0,                   8'd1,   1'b0, 1'b0, 8'd0},
    '{ROW_PIX, CFG_OP_MODE,      11'd0,                   8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_PIX, CFG_OP_MODE,      11'd0,                   8'd0,   1'b1, 1'b0, 8'd0},
    '{ROW_PIX, CFG_OP_MODE,      11'd0,                   8'd0,   1'b1, 1'b0, 8'd0},
    '{ROW_CFG, CFG_OP_MODE,      CFG_DATA_W'(OP_EDGE),    8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_CFG, CFG_IMAGE_HEIGHT, 11'd2,                   8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_PIX, CFG_OP_MODE,      11'd0,                   8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_PIX, CFG_OP_MODE,      11'd0,                   8'd254, 1'b0, 1'b0, 8'd0},
    '{ROW_PIX, CFG_OP_MODE,      11'd0,                   8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_PIX, CFG_OP_MODE,      11'd0,                   8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_PIX, CFG_OP_MODE,      11'd0,                   8'd0,   1'b1, 1'b0, 8'd0},
    '{ROW_PIX, CFG_OP_MODE,      11'd0,                   8'd0,   1'b1, 1'b0, 8'd0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  bm3_in_if  in_bus ();
  bm3_out_if out_bus ();

  binary_morphology_3x3_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  // Shadow of the block: the two previous rows, the window and the frame position.
  logic [PIX_W-1:0]      row_above2 [MAX_W];
  logic [PIX_W-1:0]      row_above1 [MAX_W];
  logic [PIX_W-1:0]      nbhd [WINDOW][WINDOW];
  int                    px_col;
  int                    px_row;
  logic [1:0]            cur_mode;
  logic [CFG_DATA_W-1:0] cur_width;
  logic [CFG_DATA_W-1:0] cur_height;

  result_t pending_px [$];
  result_t got_px;
  result_t want_px;
  int      mismatches;
  int      taken_items;
  bit      tx_calm;

  function automatic int clamp_size(logic [CFG_DATA_W-1:0] v, int lim);
    if (v == 0) begin
      return 1;
    end
    if (int'(v) > lim) begin
      return lim;
    end
    return int'(v);
  endfunction

  function automatic void begin_frame();
    for (int j = 0; j < WINDOW; j++) begin
      for (int k = 0; k < WINDOW; k++) begin
        nbhd[j][k] = PIX_OFF;
      end
    end
    px_col = 0;
    px_row = 0;
  endfunction

  function automatic void slide_window(logic [PIX_W-1:0] top, logic [PIX_W-1:0] mid,
                                       logic [PIX_W-1:0] bot);
    for (int j = 0; j < WINDOW; j++) begin
      nbhd[j][0] = nbhd[j][1];
      nbhd[j][1] = nbhd[j][2];
    end
    nbhd[0][2] = top;
    nbhd[1][2] = mid;
    nbhd[2][2] = bot;
  endfunction

  function automatic logic [PIX_W-1:0] classify_window();
    logic all_odd;
    logic any_set;
    logic any_ring;
    logic [PIX_W-1:0] mid_px;
    all_odd  = 1'b1;
    any_set  = 1'b0;
    any_ring = 1'b0;
    mid_px   = nbhd[CENTER][CENTER];
    for (int j = 0; j < WINDOW; j++) begin
      for (int k = 0; k < WINDOW; k++) begin
        if (!nbhd[j][k][0]) begin
          all_odd = 1'b0;
        end
        if (nbhd[j][k] != PIX_OFF) begin
          any_set = 1'b1;
          if (j != CENTER || k != CENTER) begin
            any_ring = 1'b1;
          end
        end
      end
    end
    case (cur_mode)
      OP_ERODE:  return (mid_px == PIX_ON && all_odd) ? PIX_ON : PIX_OFF;
      OP_DILATE: return any_set ? PIX_ON : PIX_OFF;
      OP_EDGE:   return (mid_px == PIX_OFF && any_ring) ? PIX_ON : PIX_OFF;
      default:   return PIX_OFF;
    endcase
  endfunction

  task automatic predict_pixel(input logic [PIX_W-1:0] pix, input logic fl,
                               input logic fixed, input logic [PIX_W-1:0] fixed_px,
                               output bit taken);
    int               w;
    int               h;
    int               r;
    int               c;
    int               n;
    bit               pad;
    logic [PIX_W-1:0] p;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    result_t          res [2];
    w = clamp_size(cur_width, MAX_W);
    h = clamp_size(cur_height, MAX_H);
    if (px_col >= w || px_row > h) begin
      begin_frame();
    end
    r = px_row;
    c = px_col;
    pad = (r >= h);
    taken = 1'b0;
    if (!pad && fl) begin
      return;
    end
    taken = 1'b1;
    n = 0;
    p = pad ? PIX_OFF : pix;
    top = (r >= 2) ? row_above2[c] : PIX_OFF;
    mid = (r >= 1) ? row_above1[c] : PIX_OFF;
    if (c == 0) begin
      begin_frame_window: for (int j = 0; j < WINDOW; j++) begin
        for (int k = 0; k < WINDOW; k++) begin
          nbhd[j][k] = PIX_OFF;
        end
      end
    end
    slide_window(top, mid, p);
    if (!pad) begin
      row_above2[c] = row_above1[c];
      row_above1[c] = p;
    end
    if (r >= 1 && c >= 1) begin
      res[n] = '{classify_window(), 1'b0, 1'b0};
      n++;
    end
    if (r >= 1 && c == w - 1) begin
      slide_window(PIX_OFF, PIX_OFF, PIX_OFF);
      res[n] = '{classify_window(), 1'b0, pad};
      n++;
    end
    if (n > 0) begin
      res[n-1].run_last = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      if (fixed) begin
        res[i].pixel_out = fixed_px;
      end
      pending_px = {pending_px, res[i]};
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r > h) begin
        r = 0;
      end
    end
    px_col = c;
    px_row = r;
  endtask

  function automatic int draw_gap(inout bit calm);
    int pick;
    if ($urandom_range(0, 49) == 0) begin
      calm = !calm;
    end
    if (calm) begin
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      return 0;
    end
    if (pick < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PIX_W-1:0] draw_pixel(int density);
    if ($urandom_range(0, 9) == 0) begin
      return PIX_W'($urandom_range(0, 255));
    end
    return ($urandom_range(0, 99) < density) ? PIX_ON : PIX_OFF;
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fl, input logic fixed,
                            input logic [PIX_W-1:0] fixed_px, output bit taken);
    int gap;
    @(negedge clk_i);
    in_bus.valid    <= 1'b1;
    in_bus.pixel_in <= pix;
    in_bus.flush    <= fl;
    do @(posedge clk_i); while (!in_bus.ready);
    predict_pixel(pix, fl, fixed, fixed_px, taken);
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic hold_input();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    hold_input();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    case (idx)
      CFG_OP_MODE: begin
        cur_mode = val[1:0];
      end
      CFG_IMAGE_WIDTH: begin
        cur_width = val;
        begin_frame();
      end
      CFG_IMAGE_HEIGHT: begin
        cur_height = val;
        begin_frame();
      end
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Well-formed frame from the current position, with stray flush requests in the real
  // rows and stray pixels in the flush row; a cut frame stops early, after cut_len
  // taken requests when that is nonzero.
  task automatic run_frame(input int density, input bit may_cut, input int cut_len);
    int               w;
    int               h;
    int               done;
    int               cut_at;
    bit               taken;
    logic [PIX_W-1:0] pix;
    logic             fl;
    w = clamp_size(cur_width, MAX_W);
    h = clamp_size(cur_height, MAX_H);
    cut_at = (cut_len > 0) ? cut_len : (may_cut ? $urandom_range(1, (h + 1) * w) : 0);
    done = 0;
    do begin
      if (px_row < h) begin
        if ($urandom_range(0, 99) < 4) begin
          pix = PIX_W'($urandom_range(0, 255));
          fl  = 1'b1;
        end else begin
          pix = draw_pixel(density);
          fl  = 1'b0;
        end
      end else begin
        pix = PIX_W'($urandom_range(0, 255));
        fl  = ($urandom_range(0, 9) != 0);
      end
      send_pixel(pix, fl, 1'b0, PIX_OFF, taken);
      if (taken) begin
        done++;
        taken_items++;
      end
      if ($urandom_range(0, 299) == 0) begin
        hold_input();
      end
    end while (!(done > 0 && px_row == 0 && px_col == 0) && done != cut_at);
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%s: expected px=%0d run_last=%b frame_last=%b, got px=%0d run_last=%b frame_last=%b",
               what, want_px.pixel_out, want_px.run_last, want_px.frame_last,
               got_px.pixel_out, got_px.run_last, got_px.frame_last);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got_px.pixel_out  = out_bus.pixel_out;
      got_px.run_last   = out_bus.run_last;
      got_px.frame_last = out_bus.frame_last;
      if (pending_px.size() == 0) begin
        want_px = '0;
        report_mismatch("Result with none pending");
      end else begin
        want_px = pending_px.pop_front();
        if (got_px.pixel_out != want_px.pixel_out || got_px.run_last != want_px.run_last ||
            got_px.frame_last != want_px.frame_last) begin
          report_mismatch("Result mismatch");
        end
      end
    end
  end

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int stall;
    bit calm;
    stall = 0;
    calm = 1'b0;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 49) == 0) begin
        calm = !calm;
      end
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        stall--;
      end else begin
        out_bus.ready <= 1'b1;
        if (!calm) begin
          stall = $urandom_range(0, 99);
          if (stall < 15) begin
            stall = $urandom_range(1, 3);
          end else if (stall < 18) begin
            stall = $urandom_range(10, 40);
          end else begin
            stall = 0;
          end
        end
      end
    end
  end

  initial begin
    bit   taken;
    int   phase;
    int   density;
    int   pick;
    bit   may_cut;
    int   cut_len;
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_OP_MODE;
    cfg_data        = '0;
    in_bus.valid    = 1'b0;
    in_bus.pixel_in = '0;
    in_bus.flush    = 1'b0;
    mismatches      = 0;
    taken_items     = 0;
    tx_calm         = 1'b0;
    for (int i = 0; i < MAX_W; i++) begin
      row_above2[i] = PIX_OFF;
      row_above1[i] = PIX_OFF;
    end
    cur_mode   = OP_ERODE;
    cur_width  = CFG_DATA_W'(SIZE_RESET);
    cur_height = CFG_DATA_W'(SIZE_RESET);
    begin_frame();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < $size(PLAN); i++) begin
      if (PLAN[i].kind == ROW_CFG) begin
        write_reg(PLAN[i].idx, PLAN[i].val);
      end else begin
        send_pixel(PLAN[i].pix, PLAN[i].fl, PLAN[i].fixed, PLAN[i].fixed_px, taken);
      end
    end

    taken_items = 0;
    phase = 0;
    while (taken_items < RANDOM_ITEMS) begin
      density = $urandom_range(5, 95);
      may_cut = 1'b0;
      cut_len = 0;
      if ($urandom_range(0, 4) != 0) begin
        write_reg(CFG_OP_MODE, CFG_DATA_W'($urandom_range(0, 3)));
      end
      case (phase)
        2: begin
          // Oversize sizes clamp to the maximum; the frame covers a full widest row and
          // part of the next one.
          write_reg(CFG_IMAGE_WIDTH, 11'd2047);
          write_reg(CFG_IMAGE_HEIGHT, 11'd2047);
          cut_len = MAX_W + 64;
        end
        default: begin
          may_cut = ($urandom_range(0, 9) == 0);
          if ($urandom_range(0, 5) != 0) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
              write_reg(CFG_IMAGE_WIDTH, 11'd0);
            end else if (pick == 1) begin
              write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(9, 40)));
            end else if (pick == 2) begin
              write_reg(CFG_IMAGE_WIDTH, 11'd1);
            end else begin
              write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(2, 8)));
            end
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
              write_reg(CFG_IMAGE_HEIGHT, 11'd0);
            end else if (pick == 1) begin
              write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(7, 12)));
            end else begin
              write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(1, 6)));
            end
          end
        end
      endcase
      run_frame(density, may_cut, cut_len);
      if (cut_len > 0) begin
        write_reg(CFG_IMAGE_WIDTH, 11'd4);
        write_reg(CFG_IMAGE_HEIGHT, 11'd4);
      end
      phase++;
    end

    hold_input();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_px.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
